// File: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [5:0]               entry_count;
    } rsp_t;

endpackage

// File: rtl/core/mhpq_ram.sv
module mhpq_ram (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [mhpq_pkg::IDX_W-1:0]   rd_addr,
    output logic [mhpq_pkg::DATA_W-1:0]  rd_data,
    input  logic                         wr_en,
    input  logic [mhpq_pkg::IDX_W-1:0]   wr_addr,
    input  logic [mhpq_pkg::DATA_W-1:0]  wr_data
);
    import mhpq_pkg::*;

    logic [DATA_W-1:0] mem_reg [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/max_heap_priority_queue_top.sv
// Insert: the new entry climbs one level at a time, reading the parent and comparing, until
// it reaches its place or the root. Delete: entries are scanned from slot 0 until one matches
// (no match reports ST_NO_MATCH); unless the match is the last entry, that last entry is then
// fetched into the hole and climbs or descends.
// Flow: one transaction in flight, next accepted after the result; one RAM, one read and one write port.
// Reset: entry count cleared, heap RAM contents left undefined, no clearing pass.
module max_heap_priority_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mhpq_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mhpq_pkg::rsp_t rsp
);
    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UP_RD = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_DN_RDL = 4'd3;
    localparam logic [3:0] S_DN_RDR = 4'd4;
    localparam logic [3:0] S_DN_CMP = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_LAST  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] lval_reg, lval_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic                     has_r_reg, has_r_next;
    logic                     up_only_reg, up_only_next;
    logic [1:0]               status_reg, status_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;

    logic                     accept;
    logic [IDX_W-1:0]         parent;
    logic [IDX_W:0]           left_w;
    logic [IDX_W:0]           right_w;
    logic [CNT_W:0]           cnt_w;
    logic [CNT_W:0]           scan_inc;
    logic [CNT_W-1:0]         cnt_dec;
    logic signed [DATA_W-1:0] rd_val;
    logic                     left_big;
    logic signed [DATA_W-1:0] best_val;
    logic                     right_big;

    mhpq_ram u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign parent    = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
    assign left_w    = {pos_reg, 1'b1};
    assign right_w   = left_w + (IDX_W+1)'(1);
    assign cnt_w     = (CNT_W+1)'(cnt_reg);
    assign scan_inc  = (CNT_W+1)'(scan_reg) + (CNT_W+1)'(1);
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign rd_val    = $signed(rd_data);
    assign left_big  = lval_reg > val_reg;
    assign best_val  = left_big ? lval_reg : val_reg;
    assign right_big = has_r_reg && (rd_val > best_val);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        lval_next      = lval_reg;
        has_r_next     = has_r_reg;
        up_only_next   = up_only_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_DONE;
                    val_next    = cmd.value;
                    key_next    = cmd.value;
                    if (cmd.kind == KIND_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pos_next     = IDX_W'(cnt_reg);
                            cnt_next     = cnt_reg + CNT_W'(1);
                            up_only_next = 1'b1;
                            state_next   = S_UP_RD;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        status_next = ST_NO_MATCH;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_val == key_reg)
                begin
                    cnt_next = cnt_dec;
                    if (CNT_W'(scan_reg) == cnt_dec)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(cnt_dec);
                        pos_next   = scan_reg;
                        state_next = S_LAST;
                    end
                end
                else if (scan_inc >= cnt_w)
                begin
                    status_next = ST_NO_MATCH;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(scan_inc);
                    scan_next  = IDX_W'(scan_inc);
                end
            end
            S_LAST:
            begin
                // last entry fills the hole at the matched slot
                val_next     = rd_val;
                up_only_next = 1'b0;
                state_next   = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (up_only_reg)
                    begin
                        wr_en      = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DN_RDL;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (val_reg > rd_val)
                begin
                    // pull parent down into the hole and climb
                    wr_en        = 1'b1;
                    wr_data      = rd_data;
                    pos_next     = parent;
                    up_only_next = 1'b1;
                    state_next   = S_UP_RD;
                end
                else if (up_only_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_RDL;
                end
            end
            S_DN_RDL:
            begin
                if (left_w >= (IDX_W+1)'(cnt_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(left_w);
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                lval_next  = rd_val;
                has_r_next = right_w < (IDX_W+1)'(cnt_reg);
                if (right_w < (IDX_W+1)'(cnt_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(right_w);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (right_big)
                begin
                    wr_data    = rd_data;
                    pos_next   = IDX_W'(right_w);
                    state_next = S_DN_RDL;
                end
                else if (left_big)
                begin
                    wr_data    = lval_reg;
                    pos_next   = IDX_W'(left_w);
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.top_value   = (cnt_reg == '0) ? '0 : top_reg;
                    rsp_next.entry_count = 6'(cnt_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow the root so the result needs no extra RAM read
    assign top_next = (wr_en && (wr_addr == '0)) ? $signed(wr_data) : top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        scan_reg    <= scan_next;
        val_reg     <= val_next;
        key_reg     <= key_next;
        lval_reg    <= lval_next;
        top_reg     <= top_next;
        has_r_reg   <= has_r_next;
        up_only_reg <= up_only_next;
        status_reg  <= status_next;
        rsp_reg     <= rsp_next;
    end

endmodule
